// ===== rtl/core/bsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_pkg: shared types and constants of the bitmap slot allocator
// Operation and status codes, sequencer states, field widths and the
// result record of the free-bit scan unit.
// ----------------------------------------------------------------------------
package bsa_pkg;

	// field widths
	localparam int OP_W       = 3;
	localparam int HANDLE_W   = 64;
	localparam int SLOT_IN_W  = 16;
	localparam int SLOT_OUT_W = 10;
	localparam int CODE_W     = 8;
	localparam int STATUS_W   = 2;

	// bitmap word geometry
	localparam int WORD_BITS  = 64;
	localparam int WORD_SHIFT = 6;

	// default table size and register reset value
	localparam int                SLOTS_DEF      = 1024;
	localparam logic [CODE_W-1:0] INVALID_CODE_RST = 8'd1;

	// request operation codes
	typedef enum logic [OP_W-1:0] {
		OP_ALLOC    = 3'd0,
		OP_FREE     = 3'd1,
		OP_LOOKUP   = 3'd2,
		OP_SET_CODE = 3'd3,
		OP_GET_CODE = 3'd4
	} op_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_ACCESS,
		S_RESP
	} state_t;

	// scan unit result
	typedef struct packed {
		logic                  found;
		logic [WORD_SHIFT-1:0] bit_idx;
	} scan_res_t;

endpackage

// ===== rtl/core/bsa_scan_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_scan_unit: lowest free bit finder
// Takes one 64-bit used word and a mask of bits that name real slots, and
// returns whether a free slot exists and the position of the lowest one.
// ----------------------------------------------------------------------------
module bsa_scan_unit (
	input  logic [bsa_pkg::WORD_BITS-1:0] used_word,
	input  logic [bsa_pkg::WORD_BITS-1:0] slot_mask,
	output bsa_pkg::scan_res_t            res
);

	logic [bsa_pkg::WORD_BITS-1:0] open_slots;

	// free slots that exist in the table
	assign open_slots = ~used_word & slot_mask;

	// priority pick of the lowest free bit
	always_comb begin
		res.found   = |open_slots;
		res.bit_idx = '0;
		for (int i = bsa_pkg::WORD_BITS - 1; i >= 0; i--) begin
			if (open_slots[i]) begin
				res.bit_idx = bsa_pkg::WORD_SHIFT'(i);
			end
		end
	end

endmodule

// ===== rtl/core/bitmap_slot_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator: first-free slot table with handles and close codes
// Allocates the lowest free slot from a used bitmap, frees and looks up
// slots, and keeps a per-slot close code.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result appears
// on status, slot_out, handle_out and code_out for exactly one cycle with
// done high; the receiver cannot stall, so it must take the result in that
// cycle. Allocate scans the used bitmap one 64-bit word per cycle through
// the bitmap memory's single read port and stops at the first word that
// holds a free slot, or after the last word with status full. Free, lookup
// and get-code pass through an access state and a response state (read,
// then update or respond); set-code, out-of-range indexes and unknown
// operations finish in the access state. busy drops in the cycle done is
// shown, so the next request can be taken then. After reset the close-code
// table is cleared one entry per cycle with busy high; configuration
// writes are taken at any time.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator #(
	parameter int SLOTS = bsa_pkg::SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request channel
	input  logic                             start,
	output logic                             busy,
	input  logic [bsa_pkg::OP_W-1:0]         operation,
	input  logic [bsa_pkg::HANDLE_W-1:0]     handle_in,
	input  logic signed [bsa_pkg::SLOT_IN_W-1:0] slot_in,
	input  logic [bsa_pkg::CODE_W-1:0]       code_in,
	// result channel
	output logic                             done,
	output logic [bsa_pkg::STATUS_W-1:0]     status,
	output logic [bsa_pkg::SLOT_OUT_W-1:0]   slot_out,
	output logic [bsa_pkg::HANDLE_W-1:0]     handle_out,
	output logic [bsa_pkg::CODE_W-1:0]       code_out,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bsa_pkg::CODE_W-1:0]       cfg_data
);

	localparam int SW  = $clog2(SLOTS);
	localparam int MW  = (SLOTS + bsa_pkg::WORD_BITS - 1) / bsa_pkg::WORD_BITS;
	localparam int WW  = (MW > 1) ? $clog2(MW) : 1;
	localparam int TAIL = SLOTS % bsa_pkg::WORD_BITS;
	localparam logic [bsa_pkg::WORD_BITS-1:0] TAIL_MASK =
		(TAIL == 0) ? '1 : ((64'd1 << TAIL) - 64'd1);
	localparam logic [bsa_pkg::SLOT_IN_W-1:0] SLOT_LIM = bsa_pkg::SLOT_IN_W'(SLOTS);
	localparam logic [WW-1:0] LAST_WORD = WW'(MW - 1);
	localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

	// sequencer
	bsa_pkg::state_t state_q, state_d;

	// captured request
	logic [bsa_pkg::OP_W-1:0]     op_q;
	logic [bsa_pkg::HANDLE_W-1:0] handle_q;
	logic [bsa_pkg::CODE_W-1:0]   code_q;
	logic [SW-1:0]                idx_q;
	logic                         slot_ok_q;
	logic [WW-1:0]                idx_word;

	// configuration register
	logic [bsa_pkg::CODE_W-1:0] inv_code_q;

	// clearing pass and scan counters
	logic [SW-1:0] clr_q;
	logic [WW:0]   rd_q;
	logic          rd_more;
	logic          rd_issue;
	logic          chk_vld_s1;
	logic [WW-1:0] chk_s1;

	// used bitmap memory with per-word valid bits
	logic [bsa_pkg::WORD_BITS-1:0] map_mem [MW];
	logic [MW-1:0]                 map_vld_q;
	logic [bsa_pkg::WORD_BITS-1:0] map_rd_s1;
	logic                          map_vld_s1;
	logic [bsa_pkg::WORD_BITS-1:0] map_word;
	logic [WW-1:0]                 map_raddr;
	logic                          map_we;
	logic [WW-1:0]                 map_waddr;
	logic [bsa_pkg::WORD_BITS-1:0] map_wdata;
	logic [bsa_pkg::WORD_BITS-1:0] idx_bit;

	// handle and close-code memories
	logic [bsa_pkg::HANDLE_W-1:0] handle_mem [SLOTS];
	logic [bsa_pkg::HANDLE_W-1:0] handle_rd_s1;
	logic                         handle_we;
	logic [bsa_pkg::CODE_W-1:0]   code_mem [SLOTS];
	logic [bsa_pkg::CODE_W-1:0]   code_rd_s1;
	logic                         code_we;
	logic [SW-1:0]                code_waddr;
	logic [bsa_pkg::CODE_W-1:0]   code_wdata;

	// scan unit
	bsa_pkg::scan_res_t            scan;
	logic [bsa_pkg::WORD_BITS-1:0] scan_mask;
	logic [SW-1:0]                 pos;

	// result registers
	logic                           res_load;
	bsa_pkg::status_t               res_status;
	logic [bsa_pkg::SLOT_OUT_W-1:0] res_slot;
	logic [bsa_pkg::HANDLE_W-1:0]   res_handle;
	logic [bsa_pkg::CODE_W-1:0]     res_code;
	logic                           done_q;
	bsa_pkg::status_t               status_q;
	logic [bsa_pkg::SLOT_OUT_W-1:0] slot_q;
	logic [bsa_pkg::HANDLE_W-1:0]   handle_out_q;
	logic [bsa_pkg::CODE_W-1:0]     code_out_q;

	// address helpers
	assign idx_word  = WW'(idx_q >> bsa_pkg::WORD_SHIFT);
	assign idx_bit   = 64'd1 << idx_q[bsa_pkg::WORD_SHIFT-1:0];
	assign map_word  = map_vld_s1 ? map_rd_s1 : '0;
	assign rd_more   = rd_q < (WW + 1)'(MW);
	assign map_raddr = (state_q == bsa_pkg::S_SCAN) ? rd_q[WW-1:0] : idx_word;
	assign scan_mask = (chk_s1 == LAST_WORD) ? TAIL_MASK : '1;
	assign pos       = SW'({chk_s1, scan.bit_idx});

	bsa_scan_unit u_scan (
		.used_word (map_word),
		.slot_mask (scan_mask),
		.res       (scan)
	);

	// next state and datapath control
	always_comb begin
		state_d    = state_q;
		rd_issue   = 1'b0;
		map_we     = 1'b0;
		map_waddr  = idx_word;
		map_wdata  = map_word & ~idx_bit;
		handle_we  = 1'b0;
		code_we    = 1'b0;
		code_waddr = idx_q;
		code_wdata = code_q;
		res_load   = 1'b0;
		res_status = bsa_pkg::STAT_OK;
		res_slot   = '0;
		res_handle = '0;
		res_code   = '0;
		unique case (state_q)
			bsa_pkg::S_CLEAR: begin
				code_we    = 1'b1;
				code_waddr = clr_q;
				code_wdata = '0;
				if (clr_q == LAST_SLOT) begin
					state_d = bsa_pkg::S_IDLE;
				end
			end
			bsa_pkg::S_IDLE: begin
				if (start) begin
					state_d = (operation == bsa_pkg::OP_ALLOC) ? bsa_pkg::S_SCAN
					                                           : bsa_pkg::S_ACCESS;
				end
			end
			bsa_pkg::S_SCAN: begin
				rd_issue = rd_more;
				if (chk_vld_s1 && scan.found) begin
					map_we     = 1'b1;
					map_waddr  = chk_s1;
					map_wdata  = map_word | (64'd1 << scan.bit_idx);
					handle_we  = 1'b1;
					res_load   = 1'b1;
					res_slot   = bsa_pkg::SLOT_OUT_W'(pos);
					state_d    = bsa_pkg::S_IDLE;
				end else if (chk_vld_s1 && chk_s1 == LAST_WORD) begin
					res_load   = 1'b1;
					res_status = bsa_pkg::STAT_FULL;
					state_d    = bsa_pkg::S_IDLE;
				end
			end
			bsa_pkg::S_ACCESS: begin
				if (op_q != bsa_pkg::OP_FREE && op_q != bsa_pkg::OP_LOOKUP &&
				    op_q != bsa_pkg::OP_SET_CODE && op_q != bsa_pkg::OP_GET_CODE) begin
					res_load = 1'b1;
					state_d  = bsa_pkg::S_IDLE;
				end else if (!slot_ok_q) begin
					res_load   = 1'b1;
					res_status = bsa_pkg::STAT_RANGE;
					res_code   = (op_q == bsa_pkg::OP_GET_CODE) ? inv_code_q : '0;
					state_d    = bsa_pkg::S_IDLE;
				end else if (op_q == bsa_pkg::OP_SET_CODE) begin
					code_we  = 1'b1;
					res_load = 1'b1;
					state_d  = bsa_pkg::S_IDLE;
				end else begin
					state_d = bsa_pkg::S_RESP;
				end
			end
			bsa_pkg::S_RESP: begin
				res_load = 1'b1;
				state_d  = bsa_pkg::S_IDLE;
				case (op_q)
					bsa_pkg::OP_FREE:     map_we     = 1'b1;
					bsa_pkg::OP_LOOKUP:   res_handle = (|(map_word & idx_bit)) ? handle_rd_s1 : '0;
					bsa_pkg::OP_GET_CODE: res_code   = code_rd_s1;
					default:              res_load   = 1'b1;
				endcase
			end
			default: begin
				state_d = bsa_pkg::S_CLEAR;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsa_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			rd_q       <= '0;
			chk_vld_s1 <= 1'b0;
			map_vld_q  <= '0;
			inv_code_q <= bsa_pkg::INVALID_CODE_RST;
			done_q     <= 1'b0;
		end else begin
			if (state_q == bsa_pkg::S_CLEAR) begin
				clr_q <= clr_q + SW'(1);
			end
			if (state_q == bsa_pkg::S_IDLE) begin
				rd_q <= '0;
			end else if (rd_issue) begin
				rd_q <= rd_q + (WW + 1)'(1);
			end
			chk_vld_s1 <= rd_issue;
			if (map_we) begin
				map_vld_q[map_waddr] <= 1'b1;
			end
			if (cfg_valid) begin
				inv_code_q <= cfg_data;
			end
			done_q <= res_load;
		end
	end

	// request capture and scan word tracking
	always_ff @(posedge clk) begin
		if (state_q == bsa_pkg::S_IDLE && start) begin
			op_q      <= operation;
			handle_q  <= handle_in;
			code_q    <= code_in;
			idx_q     <= SW'($unsigned(slot_in));
			slot_ok_q <= $unsigned(slot_in) < SLOT_LIM;
		end
		chk_s1 <= rd_q[WW-1:0];
	end

	// used bitmap memory
	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
		map_rd_s1  <= map_mem[map_raddr];
		map_vld_s1 <= map_vld_q[map_raddr];
	end

	// handle memory
	always_ff @(posedge clk) begin
		if (handle_we) begin
			handle_mem[pos] <= handle_q;
		end
		handle_rd_s1 <= handle_mem[idx_q];
	end

	// close-code memory
	always_ff @(posedge clk) begin
		if (code_we) begin
			code_mem[code_waddr] <= code_wdata;
		end
		code_rd_s1 <= code_mem[idx_q];
	end

	// result registers
	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q     <= res_status;
			slot_q       <= res_slot;
			handle_out_q <= res_handle;
			code_out_q   <= res_code;
		end
	end

	assign busy       = (state_q != bsa_pkg::S_IDLE);
	assign cfg_ready  = 1'b1;
	assign done       = done_q;
	assign status     = status_q;
	assign slot_out   = slot_q;
	assign handle_out = handle_out_q;
	assign code_out   = code_out_q;

`ifndef NO_ASSERTIONS
	// an accepted request keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

	// a result is shown only as the sequencer returns to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// failed requests carry no handle and no slot
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != bsa_pkg::STAT_OK |-> handle_out == '0 && slot_out == '0)
		else $error("failed request returned data");
`endif

endmodule

// ===== tb/sv/bsa_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_result_checker: outcome predictor and comparator for the slot allocator
// Watches the request, result and register write channels, keeps its own
// copy of the used bitmap, handle table and close codes, and compares every
// done strobe against the oldest predicted outcome.
// ----------------------------------------------------------------------------
module bsa_result_checker
	import bsa_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [OP_W-1:0]       operation,
	input  logic [HANDLE_W-1:0]   handle_in,
	input  logic [SLOT_IN_W-1:0]  slot_in,
	input  logic [CODE_W-1:0]     code_in,
	input  logic                  done,
	input  logic [STATUS_W-1:0]   status,
	input  logic [SLOT_OUT_W-1:0] slot_out,
	input  logic [HANDLE_W-1:0]   handle_out,
	input  logic [CODE_W-1:0]     code_out,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CODE_W-1:0]     cfg_data,
	output int                    fail_count,
	output int                    pending_count,
	output int                    answered_count,
	output int                    full_count,
	output int                    range_count
);

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [SLOT_OUT_W-1:0] slot;
		logic [HANDLE_W-1:0]   handle;
		logic [CODE_W-1:0]     code;
	} outcome_t;

	// shadow copy of the slot table
	logic [SLOTS-1:0]    used_bits;
	logic [HANDLE_W-1:0] handle_mem [SLOTS];
	logic [CODE_W-1:0]   code_mem [SLOTS];
	logic [CODE_W-1:0]   bad_slot_code;
	outcome_t            awaited_results [$];

	// apply one request to the shadow table and return its outcome
	function automatic outcome_t apply_request(
		input logic [OP_W-1:0]      op,
		input logic [HANDLE_W-1:0]  handle,
		input logic [SLOT_IN_W-1:0] slot,
		input logic [CODE_W-1:0]    code
	);
		outcome_t res;
		int       idx;
		bit       in_range;
		bit       found;
		res      = '0;
		found    = 1'b0;
		in_range = !slot[SLOT_IN_W-1] && (slot < SLOTS);
		idx      = int'(slot);
		case (op)
			OP_ALLOC: begin
				// lowest free slot wins
				for (int i = 0; i < SLOTS && !found; i++) begin
					if (!used_bits[i]) begin
						used_bits[i]  = 1'b1;
						handle_mem[i] = handle;
						res.slot      = SLOT_OUT_W'(i);
						found         = 1'b1;
					end
				end
				res.status = found ? STAT_OK : STAT_FULL;
			end
			OP_FREE, OP_LOOKUP, OP_SET_CODE, OP_GET_CODE: begin
				if (!in_range) begin
					res.status = STAT_RANGE;
					if (op == OP_GET_CODE) begin
						res.code = bad_slot_code;
					end
				end else begin
					case (op)
						OP_FREE: begin
							used_bits[idx]  = 1'b0;
							handle_mem[idx] = '0;
						end
						OP_LOOKUP: begin
							if (used_bits[idx]) begin
								res.handle = handle_mem[idx];
							end
						end
						OP_SET_CODE: begin
							code_mem[idx] = code;
						end
						default: begin
							res.code = code_mem[idx];
						end
					endcase
				end
			end
			default: begin
				// unknown opcode leaves everything zero
			end
		endcase
		return res;
	endfunction

	// predict on acceptance, compare on done
	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t want;
		int       errs;
		if (!arst_n) begin
			used_bits     = '0;
			bad_slot_code = INVALID_CODE_RST;
			for (int i = 0; i < SLOTS; i++) begin
				handle_mem[i] = '0;
				code_mem[i]   = '0;
			end
			awaited_results.delete();
			fail_count     <= 0;
			pending_count  <= 0;
			answered_count <= 0;
			full_count     <= 0;
			range_count    <= 0;
		end else begin
			errs = 0;
			if (done) begin
				if (awaited_results.size() == 0) begin
					$error("result strobe with no request outstanding");
					errs++;
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						errs++;
					end
					if (slot_out !== want.slot) begin
						$error("slot_out: expected %0d, actual %0d", want.slot, slot_out);
						errs++;
					end
					if (handle_out !== want.handle) begin
						$error("handle_out: expected %h, actual %h", want.handle, handle_out);
						errs++;
					end
					if (code_out !== want.code) begin
						$error("code_out: expected %0d, actual %0d", want.code, code_out);
						errs++;
					end
					answered_count <= answered_count + 1;
					if (want.status == STAT_FULL) begin
						full_count <= full_count + 1;
					end
					if (want.status == STAT_RANGE) begin
						range_count <= range_count + 1;
					end
				end
			end
			// register write
			if (cfg_valid && cfg_ready) begin
				bad_slot_code = cfg_data;
			end
			// accepted request
			if (start && !busy) begin
				awaited_results.push_back(apply_request(operation, handle_in, slot_in, code_in));
			end
			fail_count    <= fail_count + errs;
			pending_count <= awaited_results.size();
		end
	end

endmodule

// ===== tb/sv/bitmap_slot_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_tb: top-level bench for the bitmap slot allocator
// Drives directed corner requests, then random mixes that fill the table to
// full and churn it, across several invalid-code settings; the result
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_tb;
	import bsa_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [OP_W-1:0]       operation;
	logic [HANDLE_W-1:0]   handle_in;
	logic [SLOT_IN_W-1:0]  slot_in;
	logic [CODE_W-1:0]     code_in;
	logic                  done;
	logic [STATUS_W-1:0]   status;
	logic [SLOT_OUT_W-1:0] slot_out;
	logic [HANDLE_W-1:0]   handle_out;
	logic [CODE_W-1:0]     code_out;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CODE_W-1:0]     cfg_data;

	int                    fails;
	int                    pending;
	int                    answered;
	int                    full_hits;
	int                    range_hits;
	int                    cycle_count = 0;
	int                    alloc_issued = 0;
	bit                    steady = 1'b0;
	logic [CODE_W-1:0]     mid_code;

	bitmap_slot_allocator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.handle_in  (handle_in),
		.slot_in    (slot_in),
		.code_in    (code_in),
		.done       (done),
		.status     (status),
		.slot_out   (slot_out),
		.handle_out (handle_out),
		.code_out   (code_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	bsa_result_checker result_check (
		.*,
		.fail_count     (fails),
		.pending_count  (pending),
		.answered_count (answered),
		.full_count     (full_hits),
		.range_count    (range_hits)
	);

	// clock
	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("bitmap_slot_allocator verification failed");
			$finish;
		end
	end

	// present one request and hold it until taken
	task automatic send(
		input logic [OP_W-1:0]      op,
		input logic [HANDLE_W-1:0]  h,
		input logic [SLOT_IN_W-1:0] s,
		input logic [CODE_W-1:0]    c
	);
		start     <= 1'b1;
		operation <= op;
		handle_in <= h;
		slot_in   <= s;
		code_in   <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// random idle gap on the request side
	task automatic maybe_pause();
		if (!steady && $urandom_range(0, 99) < 9) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	endtask

	// write the invalid-code register once the block has drained
	task automatic set_bad_code(input logic [CODE_W-1:0] v);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one random request from a weighted mix, the remainder is noise
	task automatic send_mixed(input int alloc_pct, input int free_pct,
		input int look_pct, input int code_pct);
		int                   roll;
		int                   hint;
		logic [OP_W-1:0]      op;
		logic [SLOT_IN_W-1:0] s;
		roll = $urandom_range(0, 99);
		hint = (alloc_issued < SLOTS_DEF) ? alloc_issued : SLOTS_DEF - 1;
		s    = SLOT_IN_W'($urandom_range(0, hint));
		if (roll < alloc_pct) begin
			op = OP_ALLOC;
		end else if (roll < alloc_pct + free_pct) begin
			op = OP_FREE;
		end else if (roll < alloc_pct + free_pct + look_pct) begin
			op = OP_LOOKUP;
		end else if (roll < alloc_pct + free_pct + look_pct + code_pct) begin
			op = $urandom_range(0, 1) ? OP_SET_CODE : OP_GET_CODE;
			s  = SLOT_IN_W'($urandom_range(0, SLOTS_DEF - 1));
		end else begin
			op = OP_W'($urandom_range(0, 7));
			if ($urandom_range(0, 1)) begin
				s = SLOT_IN_W'($urandom);
			end else begin
				s = SLOT_IN_W'(SLOTS_DEF - 2 + $urandom_range(0, 3));
			end
		end
		if (op == OP_ALLOC) begin
			alloc_issued++;
		end
		send(op, {$urandom, $urandom}, s, CODE_W'($urandom));
	endtask

	// stimulus
	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		operation <= OP_ALLOC;
		handle_in <= '0;
		slot_in   <= '0;
		code_in   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner requests with the reset invalid code
		send(OP_GET_CODE, '0, 16'hFFFF, 8'h00);
		send(OP_GET_CODE, '0, 16'h0000, 8'h00);
		send(OP_LOOKUP, '0, 16'h0000, 8'h00);
		send(OP_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 8'hFF);
		send(OP_ALLOC, 64'h0, 16'hFFFF, 8'h00);
		send(OP_ALLOC, 64'h8000_0000_0000_0001, 16'h0000, 8'h00);
		send(OP_LOOKUP, '0, 16'h0000, 8'h00);
		send(OP_LOOKUP, '0, 16'h0002, 8'h00);
		send(OP_FREE, '0, 16'h0001, 8'h00);
		send(OP_LOOKUP, '0, 16'h0001, 8'h00);
		send(OP_ALLOC, 64'hA5A5_5A5A_0F0F_F0F0, 16'h0000, 8'h00);
		send(OP_FREE, '0, 16'h03FF, 8'h00);
		send(OP_SET_CODE, '0, 16'h03FF, 8'hFF);
		send(OP_GET_CODE, '0, 16'h03FF, 8'h00);
		send(OP_SET_CODE, '0, 16'h0000, 8'h00);
		send(OP_GET_CODE, '0, 16'h0000, 8'h00);
		send(OP_SET_CODE, '0, 16'h8000, 8'h5A);
		send(OP_LOOKUP, '0, 16'h7FFF, 8'h00);
		send(OP_FREE, '0, 16'h0400, 8'h00);
		send(OP_GET_CODE, '0, 16'h0400, 8'h00);
		send(3'd5, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 8'hFF);
		send(3'd6, 64'h1234_5678_9ABC_DEF0, 16'h0003, 8'h11);
		send(3'd7, 64'h0, 16'h0000, 8'h00);
		send(OP_FREE, '0, 16'h0000, 8'h00);
		send(OP_LOOKUP, '0, 16'h0000, 8'h00);
		alloc_issued = 4;

		// invalid code at both extremes
		set_bad_code(8'h00);
		send(OP_GET_CODE, '0, 16'hFFFF, 8'h00);
		set_bad_code(8'hFF);
		send(OP_GET_CODE, '0, 16'h8000, 8'h00);

		// balanced churn at a mid-range code
		mid_code = CODE_W'($urandom_range(2, 254));
		set_bad_code(mid_code);
		repeat (400) begin
			maybe_pause();
			send_mixed(35, 15, 20, 20);
		end

		// fill to full and keep hammering, first stretch back-to-back
		set_bad_code(8'hFF);
		for (int n = 0; n < 1150; n++) begin
			steady = (n < 350);
			maybe_pause();
			send_mixed(96, 2, 1, 1);
		end
		steady = 1'b0;

		// free-heavy churn on a full table
		set_bad_code(8'h00);
		repeat (200) begin
			maybe_pause();
			send_mixed(25, 30, 20, 20);
		end

		// drain
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (25) @(posedge clk);

		$display("%0d requests checked, %0d refused on a full table, %0d out-of-range indexes",
			answered, full_hits, range_hits);
		$display("invalid code taken from reset value through 0, 255, %0d, 255 and 0",
			mid_code);
		if (fails == 0) begin
			$display("bitmap_slot_allocator verification clean");
		end else begin
			$display("bitmap_slot_allocator verification failed");
		end
		$finish;
	end

endmodule
